@@ hw/rtl/rct_pkg.sv @@
// ----------------------------------------------------------------------------
// rct_pkg
// Shared types and constants of the request cancellation tracker.
// ----------------------------------------------------------------------------
package rct_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int HALF_W  = 64;
  localparam int KEY_W   = 2 * HALF_W;
  localparam int CMD_W   = 3;
  localparam int LIVE_W  = 5;

  localparam logic [CMD_W-1:0] CMD_REGISTER   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BEGIN      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_COMMIT     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CANCEL     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_COMPLETE   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CANCEL_ALL = 3'd6;

  localparam logic [1:0] OUTCOME_NONE      = 2'd0;
  localparam logic [1:0] OUTCOME_TOO_LATE  = 2'd1;
  localparam logic [1:0] OUTCOME_CANCELLED = 2'd2;

  typedef enum logic [1:0] {
    PH_QUEUED    = 2'd0,
    PH_EXECUTING = 2'd1,
    PH_COMMITTED = 2'd2,
    PH_CANCELLED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_EXEC = 2'd2
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [HALF_W-1:0] id_high;
    logic [HALF_W-1:0] id_low;
  } rct_in_t;

  typedef struct packed {
    logic              ok;
    logic [1:0]        cancel_outcome;
    logic              table_full;
    logic [LIVE_W-1:0] live_count;
  } rct_out_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic exec;
  } rct_ctrl_t;

  typedef struct packed {
    logic scan_last;
  } rct_stat_t;

endpackage

@@ hw/rtl/rct_ctrl.sv @@
// ----------------------------------------------------------------------------
// rct_ctrl
// Command sequencer: capture, table scan, then execute.
// ----------------------------------------------------------------------------
module rct_ctrl import rct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  rct_stat_t stat,
  output rct_ctrl_t ctrl,
  output logic      busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl.load  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctrl.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctrl.exec  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/rct_datapath.sv @@
// ----------------------------------------------------------------------------
// rct_datapath
// Slot table, scan pointer, lookup results and result register.
// ----------------------------------------------------------------------------
module rct_datapath import rct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  rct_ctrl_t ctrl,
  input  rct_in_t   request,
  output rct_stat_t stat,
  output rct_out_t  result,
  output logic      done
);

  logic [ENTRIES-1:0] slot_valid;
  logic [KEY_W-1:0]   slot_key [ENTRIES];
  phase_t             slot_phase [ENTRIES];
  logic [LIVE_W-1:0]  live;

  rct_in_t           req;
  logic [IDX_W-1:0]  idx;
  logic              found;
  logic [IDX_W-1:0]  found_idx;
  logic              free_seen;
  logic [IDX_W-1:0]  free_idx;

  logic              hit;
  phase_t            ph;
  logic              ok_next;
  logic [1:0]        outcome_next;
  logic              full_next;
  logic [LIVE_W-1:0] live_next;
  logic              wr_phase;
  phase_t            wr_phase_val;
  logic              set_valid;
  logic              clr_valid;

  assign stat.scan_last = (idx == IDX_W'(ENTRIES - 1));
  assign hit = slot_valid[idx] && (slot_key[idx] == {req.id_high, req.id_low});
  assign ph  = slot_phase[found_idx];

  always_comb begin
    ok_next      = 1'b0;
    outcome_next = OUTCOME_NONE;
    full_next    = 1'b0;
    live_next    = live;
    wr_phase     = 1'b0;
    wr_phase_val = PH_QUEUED;
    set_valid    = 1'b0;
    clr_valid    = 1'b0;
    case (req.cmd)
      CMD_REGISTER: begin
        if (!found) begin
          if (!free_seen) begin
            full_next = 1'b1;
          end else begin
            set_valid = 1'b1;
            live_next = live + LIVE_W'(1);
            ok_next   = 1'b1;
          end
        end
      end
      CMD_BEGIN: begin
        if (found && ph == PH_QUEUED) begin
          wr_phase     = 1'b1;
          wr_phase_val = PH_EXECUTING;
          ok_next      = 1'b1;
        end
      end
      CMD_COMMIT: begin
        if (found && ph == PH_COMMITTED) begin
          ok_next = 1'b1;
        end else if (found && ph == PH_EXECUTING) begin
          wr_phase     = 1'b1;
          wr_phase_val = PH_COMMITTED;
          ok_next      = 1'b1;
        end
      end
      CMD_QUERY: begin
        ok_next = found && ph == PH_CANCELLED;
      end
      CMD_CANCEL: begin
        if (found) begin
          ok_next = 1'b1;
          if (ph == PH_COMMITTED) begin
            outcome_next = OUTCOME_TOO_LATE;
          end else begin
            wr_phase     = 1'b1;
            wr_phase_val = PH_CANCELLED;
            outcome_next = OUTCOME_CANCELLED;
          end
        end
      end
      CMD_COMPLETE: begin
        if (found) begin
          clr_valid = 1'b1;
          live_next = live - LIVE_W'(1);
          ok_next   = 1'b1;
        end
      end
      CMD_CANCEL_ALL: begin
        ok_next = 1'b1;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  // scan pointer and lookup results
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      req       <= request;
      idx       <= '0;
      found     <= 1'b0;
      found_idx <= '0;
      free_seen <= 1'b0;
      free_idx  <= '0;
    end else if (ctrl.scan) begin
      if (!stat.scan_last) begin
        idx <= idx + IDX_W'(1);
      end
      if (hit && !found) begin
        found     <= 1'b1;
        found_idx <= idx;
      end
      if (!slot_valid[idx] && !free_seen) begin
        free_seen <= 1'b1;
        free_idx  <= idx;
      end
    end
  end

  // slot table
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      live       <= '0;
    end else if (ctrl.exec) begin
      live <= live_next;
      if (set_valid) begin
        slot_valid[free_idx] <= 1'b1;
      end
      if (clr_valid) begin
        slot_valid[found_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scan && req.cmd == CMD_CANCEL_ALL && slot_valid[idx]
        && slot_phase[idx] != PH_COMMITTED) begin
      slot_phase[idx] <= PH_CANCELLED;
    end else if (ctrl.exec && set_valid) begin
      slot_key[free_idx]   <= {req.id_high, req.id_low};
      slot_phase[free_idx] <= PH_QUEUED;
    end else if (ctrl.exec && wr_phase) begin
      slot_phase[found_idx] <= wr_phase_val;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      result.ok             <= ok_next;
      result.cancel_outcome <= outcome_next;
      result.table_full     <= full_next;
      result.live_count     <= live_next;
    end
  end

endmodule

@@ hw/rtl/request_cancellation_tracker_top.sv @@
// ----------------------------------------------------------------------------
// request_cancellation_tracker_top
// Table of outstanding requests keyed by a 128-bit identifier.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive request (cmd, id_high, id_low) with start high;
//   the transfer happens at a rising edge where start is high and busy low.
//   Result channel: result is valid for the single cycle in which done is
//   high and is taken at the edge that ends that cycle; the receiver cannot
//   stall it, so it must sample every done pulse.
//   Timing: the request is captured at its transfer; the scan pointer then
//   walks the 16 slots, one slot per cycle (lookup, first free slot,
//   cancel-all sweep), and the execute state updates the table and loads
//   the result and done registers. busy is low again in the cycle that
//   shows done, so the next command may be transferred then; no new
//   command is taken while one is in progress.
//   Reset (rst, synchronous): all slots become free and the live count zero;
//   keys and phases are left as they are and only read from valid slots.
// ----------------------------------------------------------------------------
module request_cancellation_tracker_top import rct_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  rct_in_t  request,
  output logic     busy,
  output rct_out_t result,
  output logic     done
);

  rct_ctrl_t ctrl;
  rct_stat_t stat;

  rct_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  rct_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .request (request),
    .stat    (stat),
    .result  (result),
    .done    (done)
  );

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while a command is still in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command transfer did not start a scan");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.table_full) |-> (!result.ok &&
      result.live_count == LIVE_W'(ENTRIES)))
    else $error("table full reported with free slots left");

  a_outcome_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.cancel_outcome != OUTCOME_NONE) |-> result.ok)
    else $error("cancel outcome without a found entry");
`endif

endmodule
